[hdl/wqvi_pkg.sv]
// wqvi_pkg: shared types and constants for the water quality valve interlock.
// Holds command and reason codes, register indexes and the limit register struct.
// No dependencies.
`default_nettype none

package wqvi_pkg;

	// item commands
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SENSOR = 2'd1,
		CMD_CLOSE  = 2'd2,
		CMD_OPEN   = 2'd3
	} wqvi_cmd_t;

	// close reasons, in failure priority order
	typedef enum logic [2:0] {
		RSN_NONE      = 3'd0,
		RSN_PH_LOW    = 3'd1,
		RSN_PH_HIGH   = 3'd2,
		RSN_TURBIDITY = 3'd3,
		RSN_SOLIDS    = 3'd4,
		RSN_TEMP_LOW  = 3'd5,
		RSN_TEMP_HIGH = 3'd6,
		RSN_REMOTE    = 3'd7
	} wqvi_rsn_t;

	// register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_PH_LOW     = 3'd0,
		REG_PH_HIGH    = 3'd1,
		REG_TURBIDITY  = 3'd2,
		REG_SOLIDS     = 3'd3,
		REG_TEMP_LOW   = 3'd4,
		REG_TEMP_HIGH  = 3'd5,
		REG_MIN_TOGGLE = 3'd6,
		REG_ALARM_MIN  = 3'd7
	} wqvi_reg_t;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// saturation points of the age counters, and seconds per minute
	localparam logic [11:0] TOGGLE_AGE_MAX = 12'hFFF;
	localparam logic [15:0] CLOSED_AGE_MAX = 16'hFFFF;
	localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

	// limit registers as seen by the datapath
	typedef struct packed {
		logic        [10:0] ph_low;
		logic        [10:0] ph_high;
		logic        [13:0] turbidity;
		logic        [13:0] solids;
		logic signed [11:0] temp_low;
		logic signed [11:0] temp_high;
		logic        [11:0] min_toggle;
		logic        [9:0]  alarm_min;
	} wqvi_cfg_t;

endpackage

`default_nettype wire

[hdl/wqvi_if.sv]
// wqvi_if: valid/ready channels for sensor/command words and result words.
// Stand-alone; no package dependency.
`default_nettype none

interface wqvi_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  command;
	logic        [10:0] ph_value;
	logic        [13:0] turbidity_value;
	logic        [13:0] solids_value;
	logic signed [11:0] temp_value;

	modport source (output valid, command, ph_value, turbidity_value, solids_value,
		temp_value, input ready);
	modport sink (input valid, command, ph_value, turbidity_value, solids_value,
		temp_value, output ready);
endinterface

interface wqvi_out_if;
	logic       valid;
	logic       ready;
	logic       valve_shut;
	logic       valve_moved;
	logic       refused;
	logic [2:0] shut_cause;
	logic       quality_safe;
	logic       long_closed_alarm;

	modport source (output valid, valve_shut, valve_moved, refused, shut_cause,
		quality_safe, long_closed_alarm, input ready);
	modport sink (input valid, valve_shut, valve_moved, refused, shut_cause,
		quality_safe, long_closed_alarm, output ready);
endinterface

`default_nettype wire

[hdl/wqvi_regs.sv]
// wqvi_regs: APB register file holding the eight interlock limits.
// Depends on wqvi_pkg (register indexes, wqvi_cfg_t).
`default_nettype none

module wqvi_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wqvi_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [wqvi_pkg::DATA_W-1:0]   pwdata,
	output logic      [wqvi_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output wqvi_pkg::wqvi_cfg_t                cfg
);

	wqvi_pkg::wqvi_cfg_t cfg_q;
	wqvi_pkg::wqvi_reg_t idx;
	logic                wr_en;

	assign idx    = wqvi_pkg::wqvi_reg_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ph_low     <= 11'd650;
			cfg_q.ph_high    <= 11'd850;
			cfg_q.turbidity  <= 14'd50;
			cfg_q.solids     <= 14'd500;
			cfg_q.temp_low   <= 12'sd0;
			cfg_q.temp_high  <= 12'sd400;
			cfg_q.min_toggle <= 12'd5;
			cfg_q.alarm_min  <= 10'd30;
		end else if (wr_en) begin
			case (idx)
				wqvi_pkg::REG_PH_LOW:     cfg_q.ph_low     <= pwdata[10:0];
				wqvi_pkg::REG_PH_HIGH:    cfg_q.ph_high    <= pwdata[10:0];
				wqvi_pkg::REG_TURBIDITY:  cfg_q.turbidity  <= pwdata[13:0];
				wqvi_pkg::REG_SOLIDS:     cfg_q.solids     <= pwdata[13:0];
				wqvi_pkg::REG_TEMP_LOW:   cfg_q.temp_low   <= $signed(pwdata[11:0]);
				wqvi_pkg::REG_TEMP_HIGH:  cfg_q.temp_high  <= $signed(pwdata[11:0]);
				wqvi_pkg::REG_MIN_TOGGLE: cfg_q.min_toggle <= pwdata[11:0];
				wqvi_pkg::REG_ALARM_MIN:  cfg_q.alarm_min  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// read mux, raw register bits zero extended
	always_comb begin
		prdata = '0;
		case (idx)
			wqvi_pkg::REG_PH_LOW:     prdata = 32'(cfg_q.ph_low);
			wqvi_pkg::REG_PH_HIGH:    prdata = 32'(cfg_q.ph_high);
			wqvi_pkg::REG_TURBIDITY:  prdata = 32'(cfg_q.turbidity);
			wqvi_pkg::REG_SOLIDS:     prdata = 32'(cfg_q.solids);
			wqvi_pkg::REG_TEMP_LOW:   prdata = 32'($unsigned(cfg_q.temp_low));
			wqvi_pkg::REG_TEMP_HIGH:  prdata = 32'($unsigned(cfg_q.temp_high));
			wqvi_pkg::REG_MIN_TOGGLE: prdata = 32'(cfg_q.min_toggle);
			wqvi_pkg::REG_ALARM_MIN:  prdata = 32'(cfg_q.alarm_min);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/wqvi_core.sv]
// wqvi_core: input register, limit check, valve state update and result register.
// Depends on wqvi_pkg (codes, wqvi_cfg_t) and wqvi_if (channel interfaces).
`default_nettype none

module wqvi_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wqvi_pkg::wqvi_cfg_t cfg,
	wqvi_in_if.sink                 in_ch,
	wqvi_out_if.source              out_ch
);

	// input stage
	logic                valid_s1;
	wqvi_pkg::wqvi_cmd_t cmd_s1;
	logic        [10:0]  ph_s1;
	logic        [13:0]  turb_s1;
	logic        [13:0]  solids_s1;
	logic signed [11:0]  temp_s1;

	// valve state
	logic                closed_q;
	logic        [11:0]  toggle_age_q;
	logic        [15:0]  closed_age_q;
	wqvi_pkg::wqvi_rsn_t reason_q;

	// result register
	logic                out_valid_q;
	logic                closed_out_q;
	logic                changed_q;
	logic                refused_q;
	wqvi_pkg::wqvi_rsn_t reason_out_q;
	logic                safe_q;
	logic                alarm_q;

	// next-state logic
	logic                adv;
	logic                fire;
	wqvi_pkg::wqvi_rsn_t why;
	wqvi_pkg::wqvi_rsn_t new_rsn;
	logic                safe;
	logic                allow;
	logic                want;
	logic                to_closed;
	logic                chg;
	logic                refuse;
	logic                closed_n;
	logic        [11:0]  toggle_n;
	logic        [15:0]  cage_n;
	wqvi_pkg::wqvi_rsn_t rsn_n;
	logic        [15:0]  alarm_secs;
	logic                alarm_n;

	// result slot frees when empty or being taken
	assign adv         = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;

	// alarm threshold in seconds; max 1023*60 fits 16 bits
	assign alarm_secs = 16'(cfg.alarm_min) * 16'(wqvi_pkg::SECS_PER_MIN);

	always_comb begin
		// first failing limit, fixed priority
		if (ph_s1 < cfg.ph_low)
			why = wqvi_pkg::RSN_PH_LOW;
		else if (ph_s1 > cfg.ph_high)
			why = wqvi_pkg::RSN_PH_HIGH;
		else if (turb_s1 > cfg.turbidity)
			why = wqvi_pkg::RSN_TURBIDITY;
		else if (solids_s1 > cfg.solids)
			why = wqvi_pkg::RSN_SOLIDS;
		else if (temp_s1 < cfg.temp_low)
			why = wqvi_pkg::RSN_TEMP_LOW;
		else if (temp_s1 > cfg.temp_high)
			why = wqvi_pkg::RSN_TEMP_HIGH;
		else
			why = wqvi_pkg::RSN_NONE;

		safe      = (cmd_s1 == wqvi_pkg::CMD_SENSOR) && (why == wqvi_pkg::RSN_NONE);
		allow     = toggle_age_q >= cfg.min_toggle;
		want      = 1'b0;
		to_closed = 1'b0;
		new_rsn   = why;

		// requested valve move
		case (cmd_s1)
			wqvi_pkg::CMD_TICK: ;
			wqvi_pkg::CMD_SENSOR: begin
				if (!safe && !closed_q) begin
					want      = 1'b1;
					to_closed = 1'b1;
				end else if (safe && closed_q) begin
					want = 1'b1;
				end
			end
			wqvi_pkg::CMD_CLOSE: begin
				want      = 1'b1;
				to_closed = 1'b1;
				new_rsn   = wqvi_pkg::RSN_REMOTE;
			end
			wqvi_pkg::CMD_OPEN: begin
				want    = 1'b1;
				new_rsn = wqvi_pkg::RSN_REMOTE;
			end
			default: ;
		endcase

		chg    = want && allow;
		refuse = want && !allow;

		closed_n = closed_q;
		toggle_n = toggle_age_q;
		cage_n   = closed_age_q;
		rsn_n    = reason_q;

		// one-second tick: saturating ages
		if (cmd_s1 == wqvi_pkg::CMD_TICK) begin
			if (toggle_age_q != wqvi_pkg::TOGGLE_AGE_MAX)
				toggle_n = toggle_age_q + 12'd1;
			if (closed_q && closed_age_q != wqvi_pkg::CLOSED_AGE_MAX)
				cage_n = closed_age_q + 16'd1;
		end

		// executed change restarts both ages
		if (chg) begin
			closed_n = to_closed;
			toggle_n = '0;
			cage_n   = '0;
			rsn_n    = to_closed ? new_rsn : wqvi_pkg::RSN_NONE;
		end

		alarm_n = closed_n && (cage_n >= alarm_secs);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1    <= wqvi_pkg::wqvi_cmd_t'(in_ch.command);
			ph_s1     <= in_ch.ph_value;
			turb_s1   <= in_ch.turbidity_value;
			solids_s1 <= in_ch.solids_value;
			temp_s1   <= in_ch.temp_value;
		end
	end

	// valve state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q     <= 1'b0;
			toggle_age_q <= '0;
			closed_age_q <= '0;
			reason_q     <= wqvi_pkg::RSN_NONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= valid_s1;
			if (fire) begin
				closed_q     <= closed_n;
				toggle_age_q <= toggle_n;
				closed_age_q <= cage_n;
				reason_q     <= rsn_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			closed_out_q <= closed_n;
			changed_q    <= chg;
			refused_q    <= refuse;
			reason_out_q <= rsn_n;
			safe_q       <= safe;
			alarm_q      <= alarm_n;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.valve_shut        = closed_out_q;
	assign out_ch.valve_moved       = changed_q;
	assign out_ch.refused           = refused_q;
	assign out_ch.shut_cause        = reason_out_q;
	assign out_ch.quality_safe      = safe_q;
	assign out_ch.long_closed_alarm = alarm_q;

`ifndef ASSERT_OFF
	// a word never reports both a change and a refusal
	a_chg_xor_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(changed_q && refused_q))
		else $error("change and refusal in one word");

	// an open valve carries no close reason
	a_open_no_rsn: assert property (@(posedge clk) disable iff (!arst_n)
		!closed_q |-> reason_q == wqvi_pkg::RSN_NONE)
		else $error("open valve with stored reason");

	// alarm only while closed
	a_alarm_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && alarm_q) |-> closed_out_q)
		else $error("alarm with valve open");

	// a safe reading can only open the valve
	a_safe_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && safe_q && changed_q) |-> !closed_out_q)
		else $error("safe reading closed the valve");

	// an executed change restarts the toggle age
	a_chg_age: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && chg) |=> (toggle_age_q == '0 && closed_age_q == '0))
		else $error("ages not restarted after change");
`endif

endmodule

`default_nettype wire

[hdl/water_quality_valve_interlock_top.sv]
// Water quality valve interlock, top level: register file and interlock core.
// Depends on wqvi_pkg, wqvi_if, wqvi_regs and wqvi_core.
//
//   channel   dir  handshake          word
//   in_ch     in   valid/ready        command, pH, turbidity, solids, temperature
//   out_ch    out  valid/ready        valve state, change, refusal, reason, safe, alarm
//   apb       in   psel/penable       eight limit registers at byte address 4*index
//
// One word per clock sustained while out_ch is ready; a word passes through the input
// register and then the result register on its way to out_ch. Valve state
// updates as a word moves into the result register. A stalled out_ch holds the result
// and lets one more word wait in the input register before in_ch.ready drops. Reset
// (arst_n low) opens the valve, clears ages and reason and loads the default limits.
`default_nettype none

module water_quality_valve_interlock_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	wqvi_in_if.sink                          in_ch,
	wqvi_out_if.source                       out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wqvi_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wqvi_pkg::DATA_W-1:0] pwdata,
	output logic      [wqvi_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);

	wqvi_pkg::wqvi_cfg_t cfg;

	wqvi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wqvi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for water_quality_valve_interlock_top: drives sensor/command words and APB writes,
// predicts every result word with a valve-state tracker and checks it field by field.
// Depends on wqvi_pkg, wqvi_if and the RTL of the interlock.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD      = 20;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		wqvi_pkg::wqvi_cmd_t command;
		logic        [10:0]  ph;
		logic        [13:0]  turb;
		logic        [13:0]  solids;
		logic signed [11:0]  temp;
	} sensor_word_t;

	typedef struct packed {
		logic                closed;
		logic                changed;
		logic                refused;
		wqvi_pkg::wqvi_rsn_t reason;
		logic                safe;
		logic                alarm;
	} valve_result_t;

	// Mirror of the valve state and limits; predicts one result per accepted word
	class valve_tracker;
		wqvi_pkg::wqvi_cfg_t cfg;
		logic                closed;
		logic [11:0]         toggle_age;
		logic [15:0]         closed_age;
		wqvi_pkg::wqvi_rsn_t reason;
		valve_result_t       awaited[$];
		int                  errors;

		function new();
			cfg.ph_low     = 11'd650;
			cfg.ph_high    = 11'd850;
			cfg.turbidity  = 14'd50;
			cfg.solids     = 14'd500;
			cfg.temp_low   = 12'sd0;
			cfg.temp_high  = 12'sd400;
			cfg.min_toggle = 12'd5;
			cfg.alarm_min  = 10'd30;
			closed     = 1'b0;
			toggle_age = '0;
			closed_age = '0;
			reason     = wqvi_pkg::RSN_NONE;
			errors     = 0;
		endfunction

		function void set_reg(wqvi_pkg::wqvi_reg_t idx, logic [31:0] v);
			case (idx)
				wqvi_pkg::REG_PH_LOW:     cfg.ph_low     = v[10:0];
				wqvi_pkg::REG_PH_HIGH:    cfg.ph_high    = v[10:0];
				wqvi_pkg::REG_TURBIDITY:  cfg.turbidity  = v[13:0];
				wqvi_pkg::REG_SOLIDS:     cfg.solids     = v[13:0];
				wqvi_pkg::REG_TEMP_LOW:   cfg.temp_low   = v[11:0];
				wqvi_pkg::REG_TEMP_HIGH:  cfg.temp_high  = v[11:0];
				wqvi_pkg::REG_MIN_TOGGLE: cfg.min_toggle = v[11:0];
				wqvi_pkg::REG_ALARM_MIN:  cfg.alarm_min  = v[9:0];
				default: ;
			endcase
		endfunction

		// first limit that fails, in priority order
		function wqvi_pkg::wqvi_rsn_t first_fault(sensor_word_t w);
			if (w.ph < cfg.ph_low) return wqvi_pkg::RSN_PH_LOW;
			if (w.ph > cfg.ph_high) return wqvi_pkg::RSN_PH_HIGH;
			if (w.turb > cfg.turbidity) return wqvi_pkg::RSN_TURBIDITY;
			if (w.solids > cfg.solids) return wqvi_pkg::RSN_SOLIDS;
			if ($signed(w.temp) < $signed(cfg.temp_low)) return wqvi_pkg::RSN_TEMP_LOW;
			if ($signed(w.temp) > $signed(cfg.temp_high)) return wqvi_pkg::RSN_TEMP_HIGH;
			return wqvi_pkg::RSN_NONE;
		endfunction

		// rate-limited valve move; 0 when refused
		function bit try_move(logic to_closed, wqvi_pkg::wqvi_rsn_t why);
			if (toggle_age < cfg.min_toggle) return 1'b0;
			closed     = to_closed;
			toggle_age = '0;
			closed_age = '0;
			reason     = to_closed ? why : wqvi_pkg::RSN_NONE;
			return 1'b1;
		endfunction

		function void take_word(sensor_word_t w);
			valve_result_t       r;
			wqvi_pkg::wqvi_rsn_t why;
			r = '0;
			case (w.command)
				wqvi_pkg::CMD_TICK: begin
					if (toggle_age < wqvi_pkg::TOGGLE_AGE_MAX) toggle_age++;
					if (closed && closed_age < wqvi_pkg::CLOSED_AGE_MAX) closed_age++;
				end
				wqvi_pkg::CMD_SENSOR: begin
					why    = first_fault(w);
					r.safe = (why == wqvi_pkg::RSN_NONE);
					if (!r.safe && !closed) begin
						if (try_move(1'b1, why)) r.changed = 1'b1;
						else r.refused = 1'b1;
					end else if (r.safe && closed) begin
						if (try_move(1'b0, wqvi_pkg::RSN_NONE)) r.changed = 1'b1;
						else r.refused = 1'b1;
					end
				end
				default: begin
					// remote commands run even when the valve already sits there
					if (try_move(w.command == wqvi_pkg::CMD_CLOSE, wqvi_pkg::RSN_REMOTE))
						r.changed = 1'b1;
					else r.refused = 1'b1;
				end
			endcase
			r.closed = closed;
			r.reason = reason;
			r.alarm  = closed && ((closed_age / wqvi_pkg::SECS_PER_MIN) >= cfg.alarm_min);
			awaited.push_back(r);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void match_result(valve_result_t got);
			valve_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$error("result word with no expectation pending");
				return;
			end
			want = awaited.pop_front();
			check_field("valve_shut", want.closed, got.closed);
			check_field("valve_moved", want.changed, got.changed);
			check_field("refused", want.refused, got.refused);
			check_field("shut_cause", want.reason, got.reason);
			check_field("quality_safe", want.safe, got.safe);
			check_field("long_closed_alarm", want.alarm, got.alarm);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [wqvi_pkg::ADDR_W-1:0]   paddr;
	logic [wqvi_pkg::DATA_W-1:0]   pwdata;
	logic [wqvi_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	bit                  tx_idle;
	bit                  rx_idle;
	bit                  hold_req;
	valve_tracker        sb;

	wqvi_in_if  in_ch();
	wqvi_out_if out_ch();

	water_quality_valve_interlock_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(PERIOD / 2) clk = ~clk;

	// run limit
	initial begin
		#(CYCLE_LIMIT * PERIOD);
		$display("FAILURE");
		$finish;
	end

	// accepted words on both channels
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.take_word(sensor_word_t'{command: wqvi_pkg::wqvi_cmd_t'(in_ch.command),
				ph: in_ch.ph_value, turb: in_ch.turbidity_value,
				solids: in_ch.solids_value, temp: in_ch.temp_value});
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.match_result(valve_result_t'{closed: out_ch.valve_shut,
				changed: out_ch.valve_moved, refused: out_ch.refused,
				reason: wqvi_pkg::wqvi_rsn_t'(out_ch.shut_cause),
				safe: out_ch.quality_safe, alarm: out_ch.long_closed_alarm});
	end

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 99) < 20) begin
				out_ch.ready <= 1'b0;
				repeat (idle_len() - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// offer one word, return at the falling edge after it is taken
	task automatic send_word(input sensor_word_t w);
		if (tx_idle && $urandom_range(0, 99) < 30) begin
			in_ch.valid <= 1'b0;
			repeat (idle_len()) @(negedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.command         <= w.command;
		in_ch.ph_value        <= w.ph;
		in_ch.turbidity_value <= w.turb;
		in_ch.solids_value    <= w.solids;
		in_ch.temp_value      <= w.temp;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait for every predicted result
	task automatic finish_phase();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write; leaves psel high so back-to-back writes need no extra edge
	task automatic write_reg(input wqvi_pkg::wqvi_reg_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic apply_cfg(input int ph_lo, input int ph_hi, input int turb, input int sol,
		input int t_lo, input int t_hi, input int min_tog, input int alarm_min);
		write_reg(wqvi_pkg::REG_PH_LOW, 32'(ph_lo));
		write_reg(wqvi_pkg::REG_PH_HIGH, 32'(ph_hi));
		write_reg(wqvi_pkg::REG_TURBIDITY, 32'(turb));
		write_reg(wqvi_pkg::REG_SOLIDS, 32'(sol));
		write_reg(wqvi_pkg::REG_TEMP_LOW, 32'(t_lo));
		write_reg(wqvi_pkg::REG_TEMP_HIGH, 32'(t_hi));
		write_reg(wqvi_pkg::REG_MIN_TOGGLE, 32'(min_tog));
		write_reg(wqvi_pkg::REG_ALARM_MIN, 32'(alarm_min));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic sensor_word_t cmd_word(input wqvi_pkg::wqvi_cmd_t c);
		sensor_word_t w;
		w.command = c;
		w.ph      = 11'($urandom);
		w.turb    = 14'($urandom);
		w.solids  = 14'($urandom);
		w.temp    = 12'($urandom);
		return w;
	endfunction

	function automatic sensor_word_t sense(input int ph, input int turb, input int sol,
		input int temp);
		sensor_word_t w;
		w.command = wqvi_pkg::CMD_SENSOR;
		w.ph      = 11'(ph);
		w.turb    = 14'(turb);
		w.solids  = 14'(sol);
		w.temp    = 12'(temp);
		return w;
	endfunction

	// in-range value when tame; boundaries, raw bits or extremes when wild
	function automatic int pick_value(input int lo, input int hi, input int bits, input bit wild);
		int full;
		full = (1 << bits) - 1;
		if (wild) begin
			case ($urandom_range(0, 9))
				0, 1: return $urandom_range(0, full);
				2: return lo - 1;
				3: return lo;
				4: return hi;
				5: return hi + 1;
				6: return $urandom_range(0, 1) ? 0 : full;
				default: ;
			endcase
		end
		if (lo <= hi) return lo + $urandom_range(0, hi - lo);
		return $urandom_range(0, full);
	endfunction

	function automatic sensor_word_t rand_word();
		sensor_word_t w;
		int           r;
		bit           wild;
		r    = $urandom_range(0, 99);
		wild = $urandom_range(0, 1);
		if (r < 45) return cmd_word(wqvi_pkg::CMD_TICK);
		if (r < 92 && r >= 85) return cmd_word(wqvi_pkg::CMD_CLOSE);
		if (r >= 92) return cmd_word(wqvi_pkg::CMD_OPEN);
		w.command = wqvi_pkg::CMD_SENSOR;
		w.ph      = 11'(pick_value(sb.cfg.ph_low, sb.cfg.ph_high, 11, wild));
		w.turb    = 14'(pick_value(0, sb.cfg.turbidity, 14, wild));
		w.solids  = 14'(pick_value(0, sb.cfg.solids, 14, wild));
		w.temp    = 12'(pick_value($signed(sb.cfg.temp_low), $signed(sb.cfg.temp_high),
			12, wild));
		return w;
	endfunction

	task automatic run_random(input int count, input bit tx, input bit rx, input bit hold);
		tx_idle = tx;
		rx_idle = rx;
		if (hold) hold_req = 1'b1;
		repeat (count) send_word(rand_word());
		finish_phase();
	endtask

	initial begin
		int k;
		arst_n                = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.command         = '0;
		in_ch.ph_value        = '0;
		in_ch.turbidity_value = '0;
		in_ch.solids_value    = '0;
		in_ch.temp_value      = '0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		tx_idle               = 1'b0;
		rx_idle               = 1'b0;
		hold_req              = 1'b0;
		sb                    = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default limits: rate limit right after reset, closing, closed-and-unsafe
		send_word(sense(0, 0, 0, 0));
		send_word(cmd_word(wqvi_pkg::CMD_CLOSE));
		repeat (5) send_word(cmd_word(wqvi_pkg::CMD_TICK));
		send_word(sense(2047, 16383, 16383, -2048));
		send_word(sense(700, 16383, 0, 200));
		send_word(sense(700, 10, 100, 200));
		send_word(cmd_word(wqvi_pkg::CMD_OPEN));
		finish_phase();

		// no rate limit, alarm at zero minutes: every reason, its priority, boundaries
		apply_cfg(650, 850, 50, 500, 0, 400, 0, 0);
		send_word(sense(649, 16383, 16383, 2047));
		send_word(sense(650, 0, 0, 0));
		send_word(sense(851, 16383, 0, 0));
		send_word(sense(850, 50, 500, 400));
		send_word(sense(700, 51, 9999, -2048));
		send_word(sense(700, 0, 0, 0));
		send_word(sense(700, 50, 501, 2047));
		send_word(sense(700, 0, 0, 0));
		send_word(sense(700, 0, 0, -1));
		send_word(sense(700, 0, 0, 0));
		send_word(sense(700, 0, 0, 401));
		send_word(cmd_word(wqvi_pkg::CMD_CLOSE));
		send_word(cmd_word(wqvi_pkg::CMD_OPEN));
		send_word(cmd_word(wqvi_pkg::CMD_OPEN));
		finish_phase();

		// random traffic under a range of limit settings
		apply_cfg(650, 850, 50, 500, 0, 400, 3, 1);
		run_random(150, 1'b1, 1'b1, 1'b0);
		apply_cfg(0, 0, 0, 0, 0, 0, 0, 0);
		run_random(100, 1'b0, 1'b0, 1'b0);
		// long receiver hold-off while words keep coming
		apply_cfg(2047, 2047, 16383, 16383, -2048, 2047, 2, 2);
		run_random(150, 1'b0, 1'b1, 1'b1);
		// inverted limits: never safe
		apply_cfg(900, 600, 30, 400, 400, 0, 1, 0);
		run_random(100, 1'b1, 1'b0, 1'b0);
		for (k = 0; k < 2; k++) begin
			apply_cfg($urandom_range(0, 1400), $urandom_range(0, 1400),
				$urandom_range(0, 10000), $urandom_range(0, 9999),
				$urandom_range(0, 1650) - 400, $urandom_range(0, 1650) - 400,
				$urandom_range(0, 10), $urandom_range(0, 3));
			run_random(150, 1'b1, 1'b1, 1'b0);
		end
		apply_cfg(0, 1400, 10000, 9999, -400, 1250, 1, 0);
		run_random(150, 1'b1, 1'b1, 1'b1);

		// closed across the one-minute alarm edge while a maximal toggle limit refuses moves
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		apply_cfg(650, 850, 50, 500, 0, 400, 0, 1);
		send_word(cmd_word(wqvi_pkg::CMD_CLOSE));
		finish_phase();
		apply_cfg(650, 850, 50, 500, 0, 400, 4095, 1);
		send_word(cmd_word(wqvi_pkg::CMD_OPEN));
		repeat (62) send_word(cmd_word(wqvi_pkg::CMD_TICK));
		send_word(cmd_word(wqvi_pkg::CMD_OPEN));
		send_word(cmd_word(wqvi_pkg::CMD_CLOSE));
		finish_phase();

		apply_cfg(700, 800, 20, 300, 100, 300, 6, 1);
		run_random(200, 1'b1, 1'b1, 1'b0);

		repeat (6) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

[filelist.f]
hdl/wqvi_pkg.sv
hdl/wqvi_if.sv
hdl/wqvi_regs.sv
hdl/wqvi_core.sv
hdl/water_quality_valve_interlock_top.sv
tb/tb.sv
